### sv/text_full_justifier_core_macros.svh
// assertion macros for the text full justifier
`ifndef TEXT_FULL_JUSTIFIER_CORE_MACROS_SVH
`define TEXT_FULL_JUSTIFIER_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define TFJ_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);
`define TFJ_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);
`else
`define TFJ_ASSERT(label, prop, msg)
`define TFJ_ASSERT_IMP(label, ante, cons, msg)
`endif
`endif

### sv/tfj_pkg.sv
// shared types and constants of the text full justifier
package tfj_pkg;
   localparam int MAX_WIDTH_DEF = 32;
   localparam logic [5:0] RESET_LINE_WIDTH = 6'd20;
   localparam logic [7:0] RESET_PAD_CHAR = 8'd46;
   localparam logic CSR_LINE_WIDTH = 1'b0;
   localparam logic CSR_PAD_CHAR = 1'b1;

   typedef struct packed {
      logic [7:0] in_char;
      logic       end_of_word;
      logic       end_of_text;
   } req_word_type;

   typedef struct packed {
      logic [7:0] out_char;
      logic       end_of_line;
      logic       last_of_run;
   } rsp_word_type;
endpackage

### sv/text_full_justifier_core.sv
// text full justifier: collects words and emits fully justified lines
//
// req channel: one word per character, with end_of_word and end_of_text flags;
// req_stall is low only while no line is being built or emitted.
// rsp channel: each emitted line is exactly line_width words (width clamped to
// 1..MAX_WIDTH), end_of_line on the final one, last_of_run on the final word
// caused by one input word.
// csr port: index 0 line_width, index 1 pad_char; write only while idle.
// an input word that ends no word gives nothing.
// a word end copies the word letter by letter from the pending memory into the
// line memory (pending read, then line write), plus a 6-step divider when a line
// is justified. each emitted character passes through a source select with line
// memory read, then the output word; each word of a line first has its length read.
// a stalled output word holds; nothing is accepted until all output of the
// current input word has gone.
// reset (synchronous) empties the held line and pending word and restores
// line_width 20 and pad_char 46; the memories need no clearing.
module text_full_justifier_core #(
   parameter int MAX_WIDTH = tfj_pkg::MAX_WIDTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  tfj_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output tfj_pkg::rsp_word_type rsp_word,
   input  logic                  csr_wr_en,
   input  logic                  csr_index,
   input  logic [7:0]            csr_wdata
);
`include "text_full_justifier_core_macros.svh"

   localparam int AW = $clog2(MAX_WIDTH);
   localparam int CW = $clog2(MAX_WIDTH + 1);
   localparam int SLOTS = (MAX_WIDTH + 1) / 2;
   localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int SCW = $clog2(SLOTS + 1);
   localparam int XW = CW + 2;
   localparam int DIVW = $clog2(CW + 1);

   typedef enum logic [3:0] {
      S_IDLE, S_CHECK, S_DIV, S_LEN, S_LOAD, S_SRC, S_OUT, S_CRD, S_CWR
   } state_type;

   logic [7:0] line_mem [MAX_WIDTH];
   logic [7:0] pend_mem [MAX_WIDTH];
   logic [CW-1:0] wlen_mem [SLOTS];

   state_type state_ff;
   logic [5:0] lwidth_ff;
   logic [7:0] pad_ff;
   logic [CW-1:0] pend_len_ff, used_ff, wl_ff, j_ff, rem_ff, gap_ff, gap_left_ff, i_ff;
   logic [CW-1:0] gaps_ff, dq_ff, dr_ff, extra_ff;
   logic [SCW-1:0] words_ff, k_ff;
   logic [AW-1:0] p_ff;
   logic [DIVW-1:0] dcnt_ff;
   logic eot_ff, just_ff, letter_ff;
   logic [7:0] line_q, pend_q;
   logic [CW-1:0] wlen_q;

   logic [CW-1:0] w_eff, pend_next, wl_new;
   logic [XW-1:0] fit_sum, jgap_sum;
   logic [CW-1:0] div_t;
   logic div_ge;
   logic accept, eow_any;
   logic line_re, pend_re, wlen_re, line_we, wlen_we, pend_we;
   logic [AW-1:0] line_raddr, line_waddr;

   always_comb begin
      if (lwidth_ff == 6'd0) begin
         w_eff = CW'(1);
      end else if (32'(lwidth_ff) > MAX_WIDTH) begin
         w_eff = CW'(MAX_WIDTH);
      end else begin
         w_eff = CW'(lwidth_ff);
      end
   end

   assign accept = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign eow_any = req_word.end_of_word || req_word.end_of_text;
   assign pend_we = accept && (pend_len_ff < w_eff);
   assign pend_next = pend_we ? pend_len_ff + CW'(1) : pend_len_ff;
   assign wl_new = (pend_next < w_eff) ? pend_next : w_eff;
   assign fit_sum = XW'(used_ff) + XW'(words_ff) + XW'(wl_ff);
   assign jgap_sum = XW'(used_ff) + XW'(words_ff) - XW'(1);
   assign div_t = {dr_ff[CW-2:0], dq_ff[CW-1]};
   assign div_ge = (div_t >= gaps_ff);

   assign line_re = (state_ff == S_SRC) && (rem_ff != '0);
   assign line_raddr = p_ff;
   assign pend_re = (state_ff == S_CRD);
   assign wlen_re = (state_ff == S_LEN);
   assign line_we = (state_ff == S_CWR);
   assign line_waddr = AW'(used_ff + i_ff);
   assign wlen_we = (state_ff == S_CWR) && (i_ff + CW'(1) == wl_ff);

   always_ff @(posedge clock) begin
      if (pend_we) begin
         pend_mem[pend_len_ff[AW-1:0]] <= req_word.in_char;
      end
      if (pend_re) begin
         pend_q <= pend_mem[i_ff[AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (line_we) begin
         line_mem[line_waddr] <= pend_q;
      end
      if (line_re) begin
         line_q <= line_mem[line_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (wlen_we) begin
         wlen_mem[words_ff[SW-1:0]] <= wl_ff;
      end
      if (wlen_re) begin
         wlen_q <= wlen_mem[k_ff[SW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         lwidth_ff <= tfj_pkg::RESET_LINE_WIDTH;
         pad_ff <= tfj_pkg::RESET_PAD_CHAR;
         pend_len_ff <= '0;
         used_ff <= '0;
         words_ff <= '0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               tfj_pkg::CSR_LINE_WIDTH: lwidth_ff <= csr_wdata[5:0];
               tfj_pkg::CSR_PAD_CHAR: pad_ff <= csr_wdata;
               default: ;
            endcase
         end
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  pend_len_ff <= pend_next;
                  if (eow_any) begin
                     eot_ff <= req_word.end_of_text;
                     wl_ff <= wl_new;
                     state_ff <= S_CHECK;
                  end
               end
            end
            S_CHECK: begin
               i_ff <= '0;
               j_ff <= '0;
               k_ff <= '0;
               p_ff <= '0;
               rem_ff <= '0;
               if (words_ff != '0 && fit_sum > XW'(w_eff)) begin
                  just_ff <= 1'b1;
                  gaps_ff <= CW'(words_ff - SCW'(1));
                  if (words_ff > SCW'(1) && jgap_sum <= XW'(w_eff)) begin
                     dq_ff <= w_eff - used_ff;
                     dr_ff <= '0;
                     dcnt_ff <= '0;
                     state_ff <= S_DIV;
                  end else begin
                     gap_ff <= CW'(1);
                     extra_ff <= '0;
                     dcnt_ff <= '0;
                     state_ff <= S_LEN;
                  end
               end else begin
                  state_ff <= S_CRD;
               end
            end
            S_DIV: begin
               dr_ff <= div_ge ? div_t - gaps_ff : div_t;
               dq_ff <= {dq_ff[CW-2:0], div_ge};
               dcnt_ff <= dcnt_ff + DIVW'(1);
               if (dcnt_ff == DIVW'(CW - 1)) begin
                  state_ff <= S_LEN;
               end
            end
            S_LEN: begin
               if (gaps_ff != '0 && dcnt_ff == DIVW'(CW) && k_ff == '0) begin
                  gap_ff <= dq_ff;
                  extra_ff <= dr_ff;
               end
               state_ff <= S_LOAD;
            end
            S_LOAD: begin
               rem_ff <= wlen_q;
               if (k_ff + SCW'(1) < words_ff) begin
                  gap_left_ff <= just_ff ?
                     gap_ff + ((CW'(k_ff) < extra_ff) ? CW'(1) : CW'(0)) : CW'(1);
               end else begin
                  gap_left_ff <= just_ff ? CW'(0) : CW'(1);
               end
               state_ff <= S_SRC;
            end
            S_SRC: begin
               if (rem_ff != '0) begin
                  letter_ff <= 1'b1;
                  p_ff <= p_ff + AW'(1);
                  rem_ff <= rem_ff - CW'(1);
                  state_ff <= S_OUT;
               end else if (gap_left_ff != '0) begin
                  letter_ff <= 1'b0;
                  gap_left_ff <= gap_left_ff - CW'(1);
                  state_ff <= S_OUT;
               end else if (k_ff + SCW'(1) < words_ff) begin
                  k_ff <= k_ff + SCW'(1);
                  state_ff <= S_LEN;
               end else begin
                  letter_ff <= 1'b0;
                  state_ff <= S_OUT;
               end
            end
            S_OUT: begin
               if (!rsp_stall) begin
                  if (j_ff + CW'(1) == w_eff) begin
                     words_ff <= '0;
                     used_ff <= '0;
                     i_ff <= '0;
                     state_ff <= just_ff ? S_CRD : S_IDLE;
                  end else begin
                     j_ff <= j_ff + CW'(1);
                     state_ff <= S_SRC;
                  end
               end
            end
            S_CRD: begin
               state_ff <= S_CWR;
            end
            S_CWR: begin
               if (i_ff + CW'(1) == wl_ff) begin
                  words_ff <= words_ff + SCW'(1);
                  used_ff <= used_ff + wl_ff;
                  pend_len_ff <= '0;
                  j_ff <= '0;
                  k_ff <= '0;
                  p_ff <= '0;
                  rem_ff <= '0;
                  if (eot_ff) begin
                     just_ff <= 1'b0;
                     gaps_ff <= '0;
                     gap_ff <= CW'(1);
                     extra_ff <= '0;
                     state_ff <= S_LEN;
                  end else begin
                     state_ff <= S_IDLE;
                  end
               end else begin
                  i_ff <= i_ff + CW'(1);
                  state_ff <= S_CRD;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid = (state_ff == S_OUT);
   always_comb begin
      rsp_word.out_char = letter_ff ? line_q : pad_ff;
      rsp_word.end_of_line = (j_ff + CW'(1) == w_eff);
      rsp_word.last_of_run = (j_ff + CW'(1) == w_eff) && (!just_ff || !eot_ff);
   end

   `TFJ_ASSERT_IMP(a_busy_when_out, rsp_valid, req_stall, "output while accepting input")
   `TFJ_ASSERT(a_words_bound, words_ff <= SCW'(SLOTS), "word count past slots")
   `TFJ_ASSERT(a_used_bound, used_ff <= CW'(MAX_WIDTH), "held letters past width")
   `TFJ_ASSERT_IMP(a_pos_bound, rsp_valid, j_ff < w_eff, "output position past width")
endmodule

### tb/tfj_checker.sv
// checker for the text full justifier: predicts justified lines and compares output words
module tfj_checker (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_stall,
   input  tfj_pkg::req_word_type req_word,
   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  tfj_pkg::rsp_word_type rsp_word,
   input  logic                  csr_wr_en,
   input  logic                  csr_index,
   input  logic [7:0]            csr_wdata,
   output int                    fail_count,
   output int                    pending_count,
   output int                    lines_seen
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAXW = tfj_pkg::MAX_WIDTH_DEF;
   localparam int SLOTS = (MAXW + 1) / 2;

   logic [7:0] line_chars [MAXW];
   logic [5:0] word_lens [SLOTS];
   logic [7:0] pend_chars [MAXW];
   int pend_len, letters_used, word_count;
   logic [5:0] width_reg;
   logic [7:0] pad_reg;
   tfj_pkg::rsp_word_type expected_words [$];
   int burst_start;

   task automatic report(input string what);
      $display("mismatch at %0t: %s", $realtime, what);
      fail_count++;
   endtask

   function automatic int clamp_width();
      int w;
      w = width_reg;
      if (w < 1) w = 1;
      if (w > MAXW) w = MAXW;
      return w;
   endfunction

   task automatic emit_held(input bit justify, input int w);
      logic [7:0] buf_c [MAXW];
      int len, p, gaps, gap, extra, cnt;
      tfj_pkg::rsp_word_type r;
      len = 0; p = 0; gap = 1; extra = 0;
      gaps = word_count > 0 ? word_count - 1 : 0;
      if (justify && gaps > 0 && letters_used + gaps <= w) begin
         gap = (w - letters_used) / gaps;
         extra = (w - letters_used) % gaps;
      end
      for (int k = 0; k < word_count && k < SLOTS; k++) begin
         for (int j = 0; j < word_lens[k]; j++) begin
            if (p < MAXW && len < w) begin
               buf_c[len] = line_chars[p];
               len++;
            end
            p++;
         end
         if (k + 1 < word_count) begin
            cnt = justify ? gap + (k < extra ? 1 : 0) : 1;
            for (int g = 0; g < cnt; g++)
               if (len < w) begin
                  buf_c[len] = pad_reg;
                  len++;
               end
         end else if (!justify && len < w) begin
            buf_c[len] = pad_reg;
            len++;
         end
      end
      while (len < w) begin
         buf_c[len] = pad_reg;
         len++;
      end
      for (int j = 0; j < w; j++) begin
         r.out_char = buf_c[j];
         r.end_of_line = (j + 1 == w);
         r.last_of_run = 1'b0;
         expected_words = {expected_words, r};
      end
      word_count = 0;
      letters_used = 0;
   endtask

   task automatic justify_step(input tfj_pkg::req_word_type x);
      int w, wl;
      w = clamp_width();
      burst_start = expected_words.size();
      if (pend_len < w) begin
         pend_chars[pend_len] = x.in_char;
         pend_len++;
      end
      if (x.end_of_word || x.end_of_text) begin
         wl = pend_len < w ? pend_len : w;
         if (word_count > 0 && letters_used + word_count + wl > w) emit_held(1'b1, w);
         if (word_count < SLOTS && letters_used + wl <= MAXW) begin
            for (int j = 0; j < wl; j++) line_chars[letters_used + j] = pend_chars[j];
            word_lens[word_count] = 6'(wl);
            word_count++;
            letters_used += wl;
         end
         pend_len = 0;
      end
      if (x.end_of_text && word_count > 0) emit_held(1'b0, w);
      if (expected_words.size() > burst_start)
         expected_words[expected_words.size() - 1].last_of_run = 1'b1;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         fail_count = 0;
         lines_seen <= 0;
         pend_len = 0; letters_used = 0; word_count = 0;
         width_reg = tfj_pkg::RESET_LINE_WIDTH;
         pad_reg = tfj_pkg::RESET_PAD_CHAR;
         expected_words.delete();
      end else begin
         if (csr_wr_en) begin
            if (csr_index == tfj_pkg::CSR_LINE_WIDTH) width_reg = csr_wdata[5:0];
            else pad_reg = csr_wdata;
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_words.size() == 0) report("output word with nothing expected");
            else begin
               tfj_pkg::rsp_word_type e;
               e = expected_words.pop_front();
               if (rsp_word.out_char !== e.out_char)
                  report($sformatf("out_char %0h expected %0h", rsp_word.out_char, e.out_char));
               if (rsp_word.end_of_line !== e.end_of_line)
                  report($sformatf("end_of_line %b expected %b",
                                   rsp_word.end_of_line, e.end_of_line));
               if (rsp_word.last_of_run !== e.last_of_run)
                  report($sformatf("last_of_run %b expected %b",
                                   rsp_word.last_of_run, e.last_of_run));
               if (e.end_of_line) lines_seen <= lines_seen + 1;
            end
         end
         if (req_valid && !req_stall) justify_step(req_word);
      end
      pending_count = expected_words.size();
   end
endmodule

### tb/testbench.sv
// testbench top for the text full justifier: stimulus, idling and verdict
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   logic clock, reset;
   logic req_valid, req_stall, rsp_valid, rsp_stall;
   tfj_pkg::req_word_type req_word;
   tfj_pkg::rsp_word_type rsp_word;
   logic csr_wr_en, csr_index;
   logic [7:0] csr_wdata;
   int fail_count, pending_count, lines_seen;
   int cycle_count, chars_sent;
   bit calm;

   text_full_justifier_core uut (.*);

   tfj_checker checker_i (.*);

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 1500000) begin
         $display("timeout");
         $display("== FAIL ==");
         $finish;
      end
   end

   always @(negedge clock) rsp_stall <= !calm && ($urandom_range(99) < 19);

   task automatic send_char(input logic [7:0] c, input bit eow, input bit eot);
      while (!calm && $urandom_range(99) < 19) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_word <= '{in_char: c, end_of_word: eow, end_of_text: eot};
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
      chars_sent++;
   endtask

   task automatic send_text(input int words, input int maxlen, input bit finish_text);
      int len;
      for (int k = 0; k < words; k++) begin
         len = $urandom_range(maxlen, 1);
         for (int j = 0; j < len; j++)
            send_char(8'($urandom_range(255)), j == len - 1,
                      finish_text && k == words - 1 && j == len - 1);
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (150) @(negedge clock);
   endtask

   task automatic write_reg(input logic idx, input logic [7:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      @(negedge clock);
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_word = '0;
      rsp_stall = 1'b0;
      csr_wr_en = 1'b0;
      csr_index = tfj_pkg::CSR_LINE_WIDTH;
      csr_wdata = '0;
      cycle_count = 0;
      chars_sent = 0;
      calm = 1'b0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      // directed: extremes, single-word line, overlong word, eot without eow
      send_char(8'h00, 1'b1, 1'b0);
      send_char(8'hff, 1'b1, 1'b0);
      send_char(8'haa, 1'b0, 1'b0);
      send_char(8'h55, 1'b1, 1'b0);
      for (int j = 0; j < 24; j++) send_char(8'(8'h41 + j), j == 23, 1'b0);
      send_char(8'h7f, 1'b0, 1'b1);
      send_char(8'h80, 1'b1, 1'b1);
      drain();
      write_reg(tfj_pkg::CSR_LINE_WIDTH, 8'd0);
      write_reg(tfj_pkg::CSR_PAD_CHAR, 8'hff);
      send_char(8'h31, 1'b0, 1'b0);
      send_char(8'h32, 1'b1, 1'b0);
      send_char(8'h33, 1'b1, 1'b1);
      drain();
      write_reg(tfj_pkg::CSR_LINE_WIDTH, 8'd32);
      write_reg(tfj_pkg::CSR_PAD_CHAR, 8'h00);
      for (int j = 0; j < 40; j++) send_char(8'(j), j == 39, 1'b0);
      send_text(10, 4, 1'b0);
      drain();
      // narrowed width with a wide held line
      write_reg(tfj_pkg::CSR_LINE_WIDTH, 8'd63);
      send_char(8'h21, 1'b1, 1'b0);
      send_char(8'h24, 1'b0, 1'b0);
      send_char(8'h25, 1'b1, 1'b0);
      drain();
      write_reg(tfj_pkg::CSR_LINE_WIDTH, 8'd3);
      send_char(8'h22, 1'b0, 1'b0);
      send_char(8'h23, 1'b0, 1'b1);
      drain();
      for (int phase = 0; phase < 8; phase++) begin
         calm = (phase == 3);
         write_reg(tfj_pkg::CSR_LINE_WIDTH, phase == 0 ? 8'd1 : phase == 1 ? 8'd32 :
                   8'($urandom_range(40, 0)));
         write_reg(tfj_pkg::CSR_PAD_CHAR, 8'($urandom_range(255)));
         while (chars_sent < 140 + phase * 42) begin
            if ($urandom_range(9) == 0) send_text($urandom_range(3, 1), 40, 1'b0);
            else send_text($urandom_range(8, 1), 7, 1'b1);
         end
         send_char(8'($urandom_range(255)), 1'b1, 1'b1);
         drain();
      end
      $display("sent %0d characters over several widths and pad codes", chars_sent);
      $display("checked %0d justified lines", lines_seen);
      if (fail_count == 0) $display("== PASS ==");
      else $display("== FAIL ==");
      $finish;
   end
endmodule
